[rtl/core/tsla_pkg.sv]
// tsla_pkg: shared types, constants and helper functions of the text line annotator.
// Used by every module of the annotator; depends on nothing.
package tsla_pkg;

    localparam int NUM_DIGITS  = 6;
    localparam int CNT_W       = 4 * NUM_DIGITS;
    localparam int POS_W       = $clog2(NUM_DIGITS + 3);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 2;

    localparam logic [POS_W-1:0] POS_FIRST = '0;
    localparam logic [POS_W-1:0] POS_TAB   = POS_W'(NUM_DIGITS);
    localparam logic [POS_W-1:0] POS_BODY0 = POS_W'(NUM_DIGITS + 1);
    localparam logic [POS_W-1:0] POS_BODY1 = POS_W'(NUM_DIGITS + 2);

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_BLANK_RUNS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd4;

    localparam logic [1:0] MODE_OFF      = 2'd0;
    localparam logic [1:0] MODE_ALL      = 2'd1;
    localparam logic [1:0] MODE_NONBLANK = 2'd2;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NL      = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_DOLLAR  = 8'd36;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_QUEST   = 8'd63;
    localparam logic [7:0] CH_CAPS_I  = 8'd73;
    localparam logic [7:0] CH_CARET   = 8'd94;
    localparam logic [7:0] CH_DEL     = 8'd127;
    localparam logic [7:0] CARET_OFFS = 8'd64;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } res_t;

    typedef struct packed {
        logic              numbered;
        logic [CNT_W-1:0]  count;
        logic              two;
        logic [7:0]        b0;
        logic [7:0]        b1;
    } job_t;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       drop_blank_runs;
        logic       show_ends;
        logic       show_tabs;
        logic       show_nonprinting;
    } cfg_t;

    // saturating BCD increment
    function automatic logic [CNT_W-1:0] bcd_inc(input logic [CNT_W-1:0] cnt);
        logic             all9;
        logic             carry;
        logic [4:0]       d;
        logic [CNT_W-1:0] res;
        all9  = 1'b1;
        carry = 1'b1;
        res   = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (cnt[4*i +: 4] != 4'd9) all9 = 1'b0;
        end
        for (int i = 0; i < NUM_DIGITS; i++) begin
            d = {1'b0, cnt[4*i +: 4]} + {4'b0, carry};
            if (d > 5'd9) begin
                d     = '0;
                carry = 1'b1;
            end else begin
                carry = 1'b0;
            end
            res[4*i +: 4] = d[3:0];
        end
        return all9 ? cnt : res;
    endfunction

    // character of the right-aligned number at position pos (most significant first)
    function automatic logic [7:0] number_char(input logic [CNT_W-1:0] cnt,
                                               input logic [POS_W-1:0] pos);
        logic       lead;
        logic [3:0] d;
        logic [7:0] ch;
        lead = 1'b1;
        ch   = CH_SPACE;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            d = cnt[4*(NUM_DIGITS-1-k) +: 4];
            if (d != 4'd0 || k == NUM_DIGITS - 1) lead = 1'b0;
            if (POS_W'(k) == pos) ch = lead ? CH_SPACE : (CH_ZERO + {4'b0, d});
        end
        return ch;
    endfunction

endpackage

[rtl/core/text_stream_line_annotator_unit.sv]
// An accepted input byte is written into the job queue; its first output byte is then
// loaded into the output register. Throughput: one input byte per cycle while each
// byte yields one output byte, the queue is not full and the output is not stalled; a
// byte that yields several output bytes holds the single output port until its last
// byte is out; a squeezed blank line is taken with no output; the output sets the pace.
// Reset (rst_n, async, low): all options off, line count 1, at line start, queue empty.
module text_stream_line_annotator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  tsla_pkg::item_t                 item,
    output logic                            res_valid,
    input  logic                            res_stall,
    output tsla_pkg::res_t                  res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tsla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsla_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic            q_full, q_empty, q_push, q_pop;
    tsla_pkg::job_t  q_job, q_head;

    tsla_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (q_job)
    );

    tsla_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    tsla_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

[rtl/core/tsla_front.sv]
// tsla_front: accepts input bytes, holds the configuration registers and line state,
// and turns each byte not squeezed into a job for the back end. Depends on tsla_pkg.
module tsla_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  tsla_pkg::item_t              item,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tsla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsla_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                         q_full,
    output logic                         q_push,
    output tsla_pkg::job_t               q_job
);

    tsla_pkg::cfg_t                  cfg_reg, cfg_next;
    logic                            at_line_start_reg, at_line_start_next;
    logic                            prev_blank_reg, prev_blank_next;
    logic [tsla_pkg::CNT_W-1:0]      count_reg, count_next;

    logic                            accept;
    logic                            line_start;
    logic                            pblank;
    logic [tsla_pkg::CNT_W-1:0]      count_cur;
    logic                            blank;
    logic                            squeezed;
    logic                            numbered;
    logic [7:0]                      c;

    assign cfg_ready  = 1'b1;
    assign item_stall = q_full;
    assign accept     = item_valid && !item_stall;
    assign c          = item.data_byte;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tsla_pkg::CFG_NUMBER_MODE:      cfg_next.number_mode      = cfg_data;
                tsla_pkg::CFG_DROP_BLANK_RUNS:  cfg_next.drop_blank_runs  = cfg_data[0];
                tsla_pkg::CFG_SHOW_ENDS:        cfg_next.show_ends        = cfg_data[0];
                tsla_pkg::CFG_SHOW_TABS:        cfg_next.show_tabs        = cfg_data[0];
                tsla_pkg::CFG_SHOW_NONPRINTING: cfg_next.show_nonprinting = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        line_start = item.file_start || at_line_start_reg;
        pblank     = item.file_start ? 1'b0 : prev_blank_reg;
        count_cur  = item.file_start ? tsla_pkg::CNT_ONE : count_reg;
        blank      = (c == tsla_pkg::CH_NL);
        squeezed   = line_start && cfg_reg.drop_blank_runs && blank && pblank;
        numbered   = line_start && !squeezed &&
                     ((cfg_reg.number_mode == tsla_pkg::MODE_ALL) ||
                      (cfg_reg.number_mode == tsla_pkg::MODE_NONBLANK && !blank));

        q_job.numbered = numbered;
        q_job.count    = count_cur;
        q_job.two      = 1'b0;
        q_job.b0       = c;
        q_job.b1       = c;
        if (c == tsla_pkg::CH_TAB && cfg_reg.show_tabs)
        begin
            q_job.two = 1'b1;
            q_job.b0  = tsla_pkg::CH_CARET;
            q_job.b1  = tsla_pkg::CH_CAPS_I;
        end
        else if (blank)
        begin
            q_job.two = cfg_reg.show_ends;
            q_job.b0  = cfg_reg.show_ends ? tsla_pkg::CH_DOLLAR : tsla_pkg::CH_NL;
            q_job.b1  = tsla_pkg::CH_NL;
        end
        else if (cfg_reg.show_nonprinting && c < tsla_pkg::CH_SPACE && c != tsla_pkg::CH_TAB)
        begin
            q_job.two = 1'b1;
            q_job.b0  = tsla_pkg::CH_CARET;
            q_job.b1  = c + tsla_pkg::CARET_OFFS;
        end
        else if (cfg_reg.show_nonprinting && c == tsla_pkg::CH_DEL)
        begin
            q_job.two = 1'b1;
            q_job.b0  = tsla_pkg::CH_CARET;
            q_job.b1  = tsla_pkg::CH_QUEST;
        end

        q_push = accept && !squeezed;

        at_line_start_next = at_line_start_reg;
        prev_blank_next    = prev_blank_reg;
        count_next         = count_reg;
        if (accept)
        begin
            count_next         = numbered ? tsla_pkg::bcd_inc(count_cur) : count_cur;
            at_line_start_next = squeezed || blank;
            prev_blank_next    = line_start ? (cfg_reg.drop_blank_runs && blank) : pblank;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg           <= '0;
            at_line_start_reg <= 1'b1;
            prev_blank_reg    <= 1'b0;
            count_reg         <= tsla_pkg::CNT_ONE;
        end
        else
        begin
            cfg_reg           <= cfg_next;
            at_line_start_reg <= at_line_start_next;
            prev_blank_reg    <= prev_blank_next;
            count_reg         <= count_next;
        end
    end

endmodule

[rtl/core/tsla_queue.sv]
// tsla_queue: short job queue that decouples the front end from the back end.
// Depends on tsla_pkg.
module tsla_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tsla_pkg::job_t  push_job,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output tsla_pkg::job_t  head
);

    tsla_pkg::job_t                   mem_reg [tsla_pkg::QUEUE_DEPTH];
    logic [tsla_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [tsla_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [tsla_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;
    logic                             do_push, do_pop;

    assign full    = (cnt_reg == tsla_pkg::QCNT_W'(tsla_pkg::QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + tsla_pkg::QCNT_W'(do_push) - tsla_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

[rtl/core/tsla_back.sv]
// tsla_back: walks the head job byte by byte (number, tab, body) into the output register.
// Depends on tsla_pkg.
module tsla_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  tsla_pkg::job_t  head,
    output logic            q_pop,
    output logic            res_valid,
    input  logic            res_stall,
    output tsla_pkg::res_t  res
);

    logic                          mid_reg, mid_next;
    logic [tsla_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic                          res_valid_reg, res_valid_next;
    tsla_pkg::res_t                res_reg, res_next;

    logic                          load;
    logic [tsla_pkg::POS_W-1:0]    pos;
    logic                          last;
    logic [7:0]                    ch;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign load      = !res_valid_reg || !res_stall;

    always_comb
    begin
        if (mid_reg)
            pos = pos_reg;
        else
            pos = head.numbered ? tsla_pkg::POS_FIRST : tsla_pkg::POS_BODY0;

        last = (pos == tsla_pkg::POS_BODY1) || (pos == tsla_pkg::POS_BODY0 && !head.two);

        if (pos == tsla_pkg::POS_TAB)
            ch = tsla_pkg::CH_TAB;
        else if (pos == tsla_pkg::POS_BODY0)
            ch = head.b0;
        else if (pos == tsla_pkg::POS_BODY1)
            ch = head.b1;
        else
            ch = tsla_pkg::number_char(head.count, pos);

        q_pop          = load && !q_empty && last;
        mid_next       = mid_reg;
        pos_next       = pos_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (load)
        begin
            res_valid_next       = !q_empty;
            res_next.out_byte    = ch;
            res_next.last_of_run = last;
            if (!q_empty)
            begin
                mid_next = !last;
                pos_next = pos + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg       <= 1'b0;
            pos_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            mid_reg       <= mid_next;
            pos_reg       <= pos_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

[rtl/core/tsla_checker.sv]
// tsla_checker: port-level assertions for the text line annotator, bound to the top level.
// Depends on tsla_pkg and text_stream_line_annotator_unit.
module tsla_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            res_valid,
    input  logic            res_stall,
    input  tsla_pkg::res_t  res
);

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("output valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled request changed");

    a_newline_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.out_byte == tsla_pkg::CH_NL |-> res.last_of_run)
        else $error("newline not last of run");

    a_end_mark: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && res.out_byte == tsla_pkg::CH_DOLLAR && !res.last_of_run
        |=> res_valid && res.out_byte == tsla_pkg::CH_NL && res.last_of_run)
        else $error("end mark not followed by newline");

    a_caret_pair: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && res.out_byte == tsla_pkg::CH_CARET && !res.last_of_run
        |=> res_valid && res.last_of_run)
        else $error("caret not followed by final byte");

endmodule

bind text_stream_line_annotator_unit tsla_checker u_tsla_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

[test/text_stream_line_annotator_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for text_stream_line_annotator_unit: numbering, squeezing and
// caret display are predicted per request and compared byte by byte with the output stream.
// Depends on tsla_pkg and the annotator RTL only.
module text_stream_line_annotator_unit_tb;

    import tsla_pkg::*;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam logic [3:0] BY_PREDICTOR  = 4'hF;
    localparam int         LATENCY_PAD   = 8;
    localparam int         DRAIN_LIMIT   = 20000;
    localparam int         LONG_HOLD     = 60;
    localparam int         RANDOM_PHASES = 6;
    localparam int         PHASE_ITEMS   = 18;
    localparam int         RAMP_LINES    = 110;
    localparam longint     TIMEOUT_NS    = 2000000;

    localparam cfg_t C_PLAIN     = '{MODE_OFF, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam cfg_t C_NUM_ENDS  = '{MODE_ALL, 1'b0, 1'b1, 1'b0, 1'b0};
    localparam cfg_t C_NB_SHOW   = '{MODE_NONBLANK, 1'b1, 1'b0, 1'b1, 1'b1};
    localparam cfg_t C_ODD_MODE  = '{MODE_UNUSED, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam cfg_t C_ALL_ON    = '{MODE_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1};
    localparam cfg_t C_COUNT_RUN = '{MODE_ALL, 1'b0, 1'b0, 1'b0, 1'b0};

    typedef struct packed {
        cfg_t        cfg;
        item_t       req;
        logic [3:0]  golden_len;
        logic [71:0] golden;
    } row_t;

    // golden bytes are listed first-out first, right-justified
    localparam row_t SCRIPT [0:25] = '{
        '{C_PLAIN,    '{"A",      1'b1}, 4'd1, 72'("A")},
        '{C_PLAIN,    '{8'h00,    1'b0}, 4'd1, 72'h00},
        '{C_PLAIN,    '{8'hFF,    1'b0}, 4'd1, 72'hFF},
        '{C_PLAIN,    '{CH_NL,    1'b0}, 4'd1, 72'("\n")},
        '{C_NUM_ENDS, '{"x",      1'b1}, 4'd8, 72'("     1\tx")},
        '{C_NUM_ENDS, '{CH_NL,    1'b0}, 4'd2, 72'("$\n")},
        '{C_NUM_ENDS, '{CH_NL,    1'b0}, 4'd9, 72'("     2\t$\n")},
        '{C_NUM_ENDS, '{CH_DEL,   1'b0}, BY_PREDICTOR, 72'd0},
        '{C_NUM_ENDS, '{CH_TAB,   1'b0}, 4'd1, 72'("\t")},
        '{C_NB_SHOW,  '{CH_NL,    1'b0}, 4'd1, 72'("\n")},
        '{C_NB_SHOW,  '{CH_NL,    1'b0}, 4'd1, 72'("\n")},
        '{C_NB_SHOW,  '{CH_NL,    1'b0}, 4'd0, 72'd0},
        '{C_NB_SHOW,  '{CH_TAB,   1'b0}, 4'd9, 72'("     4\t^I")},
        '{C_NB_SHOW,  '{8'h01,    1'b0}, 4'd2, 72'("^A")},
        '{C_NB_SHOW,  '{8'h1F,    1'b0}, 4'd2, 72'("^_")},
        '{C_NB_SHOW,  '{CH_DEL,   1'b0}, 4'd2, 72'("^?")},
        '{C_NB_SHOW,  '{8'h80,    1'b0}, 4'd1, 72'h80},
        '{C_NB_SHOW,  '{CH_NL,    1'b0}, 4'd1, 72'("\n")},
        '{C_NB_SHOW,  '{CH_NL,    1'b1}, 4'd1, 72'("\n")},
        '{C_NB_SHOW,  '{CH_NL,    1'b0}, 4'd0, 72'd0},
        '{C_NB_SHOW,  '{"a",      1'b0}, BY_PREDICTOR, 72'd0},
        '{C_NB_SHOW,  '{"b",      1'b1}, 4'd8, 72'("     1\tb")},
        '{C_ODD_MODE, '{CH_TAB,   1'b0}, 4'd1, 72'("\t")},
        '{C_ODD_MODE, '{8'h00,    1'b0}, 4'd2, 72'("^@")},
        '{C_ODD_MODE, '{CH_NL,    1'b0}, 4'd1, 72'("\n")},
        '{C_ODD_MODE, '{"q",      1'b0}, 4'd1, 72'("q")}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_stall;
    item_t                 item;
    logic                  res_valid;
    logic                  res_stall;
    res_t                  res;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // annotator state as predicted
    cfg_t             active_cfg;
    logic             at_start;
    logic             last_kept_blank;
    logic [CNT_W-1:0] next_line_no;

    logic [7:0] run_bytes[$];
    res_t       pending_bytes[$];

    int  mismatch_count;
    int  requests_sent;
    int  bytes_checked;
    int  settings_applied;
    bit  tx_rush;
    bit  rx_rush;
    bit  hold_long;

    text_stream_line_annotator_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // bytes one request produces; empty for a squeezed blank line
    function automatic void annotate(input item_t req);
        logic [7:0] c;
        logic       blank;
        logic       lead;
        logic       carry;
        logic [3:0] digit;
        c = req.data_byte;
        run_bytes.delete();
        if (req.file_start)
        begin
            next_line_no    = CNT_W'(1);
            last_kept_blank = 1'b0;
            at_start        = 1'b1;
        end
        if (at_start)
        begin
            blank = (c == CH_NL);
            if (active_cfg.drop_blank_runs && blank)
            begin
                if (last_kept_blank)
                    return;
                last_kept_blank = 1'b1;
            end
            else
                last_kept_blank = 1'b0;
            if (active_cfg.number_mode == MODE_ALL ||
                (active_cfg.number_mode == MODE_NONBLANK && !blank))
            begin
                lead = 1'b1;
                for (int k = NUM_DIGITS - 1; k >= 0; k--)
                begin
                    digit = next_line_no[4*k +: 4];
                    if (digit != 4'd0 || k == 0)
                        lead = 1'b0;
                    run_bytes.push_back(lead ? CH_SPACE : CH_ZERO + 8'(digit));
                end
                run_bytes.push_back(CH_TAB);
                // BCD count, held at all nines
                if (next_line_no != {NUM_DIGITS{4'd9}})
                begin
                    carry = 1'b1;
                    for (int k = 0; k < NUM_DIGITS; k++)
                    begin
                        if (carry)
                        begin
                            if (next_line_no[4*k +: 4] == 4'd9)
                                next_line_no[4*k +: 4] = 4'd0;
                            else
                            begin
                                next_line_no[4*k +: 4] = next_line_no[4*k +: 4] + 4'd1;
                                carry = 1'b0;
                            end
                        end
                    end
                end
            end
            at_start = 1'b0;
        end
        if (c == CH_TAB && active_cfg.show_tabs)
        begin
            run_bytes.push_back(CH_CARET);
            run_bytes.push_back(CH_CAPS_I);
        end
        else if (c == CH_NL)
        begin
            if (active_cfg.show_ends)
                run_bytes.push_back(CH_DOLLAR);
            run_bytes.push_back(CH_NL);
            at_start = 1'b1;
        end
        else if (active_cfg.show_nonprinting && c < CH_SPACE && c != CH_TAB)
        begin
            run_bytes.push_back(CH_CARET);
            run_bytes.push_back(c + CARET_OFFS);
        end
        else if (active_cfg.show_nonprinting && c == CH_DEL)
        begin
            run_bytes.push_back(CH_CARET);
            run_bytes.push_back(CH_QUEST);
        end
        else
            run_bytes.push_back(c);
    endfunction

    task automatic deliver(input item_t req, input logic [3:0] golden_len,
                           input logic [71:0] golden);
        int gap;
        gap = tx_rush ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= req;
        do @(posedge clk); while (!(item_valid && !item_stall));
        annotate(req);
        if (golden_len != BY_PREDICTOR)
        begin
            run_bytes.delete();
            for (int i = 0; i < golden_len; i++)
                run_bytes.push_back(golden[8*(golden_len - 1 - i) +: 8]);
        end
        foreach (run_bytes[i])
            pending_bytes.push_back('{run_bytes[i], 1'(i == run_bytes.size() - 1)});
        requests_sent++;
    endtask

    // stop sending and wait for the output side to catch up
    task automatic drain();
        int waited;
        item_valid <= 1'b0;
        waited = 0;
        while (pending_bytes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_bytes.size() != 0)
        begin
            report_mismatch($sformatf("%0d output bytes never arrived", pending_bytes.size()));
            pending_bytes.delete();
        end
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    task automatic apply_config(input cfg_t setting);
        logic [CFG_DATA_W-1:0] value;
        for (int r = 0; r <= CFG_SHOW_NONPRINTING; r++)
        begin
            case (CFG_IDX_W'(r))
                CFG_NUMBER_MODE:      value = setting.number_mode;
                CFG_DROP_BLANK_RUNS:  value = {1'b0, setting.drop_blank_runs};
                CFG_SHOW_ENDS:        value = {1'b0, setting.show_ends};
                CFG_SHOW_TABS:        value = {1'b0, setting.show_tabs};
                CFG_SHOW_NONPRINTING: value = {1'b0, setting.show_nonprinting};
                default:              value = '0;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_data  <= value;
            do @(posedge clk); while (!(cfg_valid && cfg_ready));
        end
        cfg_valid <= 1'b0;
        active_cfg = setting;
        settings_applied++;
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_bytes.size() == 0)
                report_mismatch($sformatf("unexpected output byte 0x%02h", res.out_byte));
            else
            begin
                want = pending_bytes.pop_front();
                if (res.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                              res.out_byte, want.out_byte));
                if (res.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %b, expected %b on byte 0x%02h",
                                              res.last_of_run, want.last_of_run, want.out_byte));
                bytes_checked++;
            end
        end
    end

    // output side: random stall per byte, one long hold on request
    initial
    begin
        int pause;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_long)
            begin
                res_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_long = 1'b0;
            end
            pause = rx_rush ? 0 : $urandom_range(0, 8);
            if (pause > 0)
            begin
                res_stall <= 1'b1;
                repeat (pause) @(posedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!(res_valid && !res_stall));
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        cfg_t       setting;
        logic [7:0] b;
        int         sent_in_phase;
        int         lines_in_phase;
        int         line_len;
        bit         new_file;

        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        res_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        active_cfg      = C_PLAIN;
        at_start        = 1'b1;
        last_kept_blank = 1'b0;
        next_line_no    = CNT_W'(1);
        mismatch_count   = 0;
        requests_sent    = 0;
        bytes_checked    = 0;
        settings_applied = 0;
        tx_rush   = 1'b0;
        rx_rush   = 1'b0;
        hold_long = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apply_config(C_PLAIN);

        foreach (SCRIPT[i])
        begin
            if (SCRIPT[i].cfg != active_cfg)
            begin
                drain();
                apply_config(SCRIPT[i].cfg);
            end
            deliver(SCRIPT[i].req, SCRIPT[i].golden_len, SCRIPT[i].golden);
        end

        // random text: mostly whole lines, some merged lines and stray file starts
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            setting = (phase == 0) ? C_ALL_ON : cfg_t'($urandom);
            drain();
            apply_config(setting);
            tx_rush = (phase == 2 || phase == 3);
            rx_rush = (phase == 2);
            if (phase == 3)
                hold_long = 1'b1;
            sent_in_phase  = 0;
            lines_in_phase = 0;
            while (sent_in_phase < PHASE_ITEMS)
            begin
                line_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                new_file = ($urandom_range(0, 15) == 0);
                for (int j = 0; j < line_len; j++)
                begin
                    case ($urandom_range(0, 7))
                        0, 1, 2: b = 8'($urandom_range(32, 126));
                        3:       b = CH_TAB;
                        4:       b = 8'($urandom_range(0, 31));
                        5:       b = CH_DEL;
                        6:       b = 8'($urandom_range(128, 255));
                        default: b = 8'($urandom);
                    endcase
                    deliver('{b, 1'((j == 0 && new_file) || $urandom_range(0, 40) == 0)},
                            BY_PREDICTOR, '0);
                    sent_in_phase++;
                end
                if ($urandom_range(0, 7) != 0)
                begin
                    deliver('{CH_NL, 1'(line_len == 0 && new_file)}, BY_PREDICTOR, '0);
                    sent_in_phase++;
                end
                lines_in_phase++;
                if (phase == 4 && lines_in_phase == 4)
                    drain();
            end
        end

        // count run past two decimal carries to exercise BCD and the number alignment
        drain();
        apply_config(C_COUNT_RUN);
        tx_rush = 1'b1;
        rx_rush = 1'b1;
        for (int i = 0; i < RAMP_LINES; i++)
            deliver('{CH_NL, 1'(i == 0)}, BY_PREDICTOR, '0);
        drain();

        $display("Covered %0d requests, %0d output bytes compared, %0d register settings",
                 requests_sent, bytes_checked, settings_applied);
        $display("Numbering modes, squeezing, caret display and a %0d-line count run; %0d errors",
                 RAMP_LINES, mismatch_count);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[text_stream_line_annotator_unit.f]
rtl/core/tsla_pkg.sv
rtl/core/tsla_front.sv
rtl/core/tsla_queue.sv
rtl/core/tsla_back.sv
rtl/core/text_stream_line_annotator_unit.sv
rtl/core/tsla_checker.sv
test/text_stream_line_annotator_unit_tb.sv
